FILE: src/btpc_pkg.sv
// Shared types, constants and the compensation microprogram for the barometric block.
package btpc_pkg;

  // Input beat: raw samples with their presence flags.
  typedef struct packed {
    logic        temp_present;
    logic [23:0] raw_temperature;
    logic        press_present;
    logic [23:0] raw_pressure;
  } in_t;

  // Output beat: binary32 results with their valid flags.
  typedef struct packed {
    logic        temp_ok;
    logic [31:0] temperature_bits;
    logic        press_ok;
    logic [31:0] pressure_bits;
  } out_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LO  = 2'd0;
  localparam logic [1:0] CFG_MID = 2'd1;
  localparam logic [1:0] CFG_HI  = 2'd2;

  // Operations of the shared floating-point unit.
  typedef enum logic [1:0] {FP_ADD, FP_SUB, FP_MUL, FP_CVT} fp_op_t;

  // Operand sources.
  typedef enum logic [1:0] {SRC_RAM, SRC_TEMP, SRC_INT} src_t;

  // Integer operands for conversion.
  typedef enum logic [3:0] {
    INT_T1, INT_T2, INT_T3, INT_RAWT,
    INT_P1, INT_P2, INT_P3, INT_P4, INT_P5, INT_P6,
    INT_P7, INT_P8, INT_P9, INT_P10, INT_P11, INT_RAWP
  } isel_t;

  // What happens when a step completes.
  typedef enum logic [1:0] {END_NONE, END_TEMP, END_PRESS} end_t;

  localparam int SLOT_W = 5;
  localparam int INT_W  = 25;
  localparam int ADJ_W  = 8;
  localparam int PC_W   = 6;

  // The scratch memory holds exactly one entry per slot address.
  localparam int SCRATCH_DEPTH = 1 << SLOT_W;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PC_W-1:0]   pc_t;

  // Scratch slots in the operand memory.
  localparam slot_t SL_T1   = 5'd0;
  localparam slot_t SL_T2   = 5'd1;
  localparam slot_t SL_T3   = 5'd2;
  localparam slot_t SL_X    = 5'd3;
  localparam slot_t SL_DT   = 5'd4;
  localparam slot_t SL_A    = 5'd5;
  localparam slot_t SL_SQ   = 5'd6;
  localparam slot_t SL_B    = 5'd7;
  localparam slot_t SL_P1   = 5'd8;
  localparam slot_t SL_P2   = 5'd9;
  localparam slot_t SL_P3   = 5'd10;
  localparam slot_t SL_P4   = 5'd11;
  localparam slot_t SL_P5   = 5'd12;
  localparam slot_t SL_P6   = 5'd13;
  localparam slot_t SL_P7   = 5'd14;
  localparam slot_t SL_P8   = 5'd15;
  localparam slot_t SL_P9   = 5'd16;
  localparam slot_t SL_P10  = 5'd17;
  localparam slot_t SL_P11  = 5'd18;
  localparam slot_t SL_UP   = 5'd19;
  localparam slot_t SL_TT   = 5'd20;
  localparam slot_t SL_TTT  = 5'd21;
  localparam slot_t SL_UP2  = 5'd22;
  localparam slot_t SL_UP3  = 5'd23;
  localparam slot_t SL_M    = 5'd24;
  localparam slot_t SL_O1   = 5'd25;
  localparam slot_t SL_S    = 5'd26;
  localparam slot_t SL_O2   = 5'd27;
  localparam slot_t SL_O3   = 5'd28;
  localparam slot_t SL_O4   = 5'd29;
  localparam slot_t SL_RES  = 5'd30;
  localparam slot_t SL_TN   = 5'd31;

  localparam pc_t PC_PRESS = 6'd9;
  localparam pc_t PC_LAST  = 6'd44;

  // One microinstruction.
  typedef struct packed {
    fp_op_t                   op;
    src_t                     a_src;
    slot_t                    a_addr;
    src_t                     b_src;
    slot_t                    b_addr;
    slot_t                    dst;
    isel_t                    isel;
    logic signed [ADJ_W-1:0]  adj;
    end_t                     endk;
  } uop_t;

  // Command handed to the floating-point unit.
  typedef struct packed {
    fp_op_t                   op;
    logic [31:0]              a;
    logic [31:0]              b;
    logic signed [INT_W-1:0]  ival;
    logic signed [ADJ_W-1:0]  adj;
  } fp_cmd_t;

  // Arithmetic step between two slots.
  function automatic uop_t ar(fp_op_t op, src_t as, slot_t aa, src_t bs, slot_t ba,
                              slot_t dst, end_t e);
    uop_t u;
    u.op     = op;
    u.a_src  = as;
    u.a_addr = aa;
    u.b_src  = bs;
    u.b_addr = ba;
    u.dst    = dst;
    u.isel   = INT_T1;
    u.adj    = '0;
    u.endk   = e;
    return u;
  endfunction

  // Integer conversion step, scaled by a power of two.
  function automatic uop_t cv(isel_t s, logic signed [ADJ_W-1:0] adj, slot_t dst);
    uop_t u;
    u.op     = FP_CVT;
    u.a_src  = SRC_INT;
    u.a_addr = '0;
    u.b_src  = SRC_RAM;
    u.b_addr = '0;
    u.dst    = dst;
    u.isel   = s;
    u.adj    = adj;
    u.endk   = END_NONE;
    return u;
  endfunction

  // The compensation program. Temperature first, pressure from PC_PRESS.
  function automatic uop_t btpc_prog(pc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = cv(INT_T1, 8'sd8, SL_T1);
      6'd1:  u = cv(INT_T2, -8'sd30, SL_T2);
      6'd2:  u = cv(INT_T3, -8'sd48, SL_T3);
      6'd3:  u = cv(INT_RAWT, 8'sd0, SL_X);
      6'd4:  u = ar(FP_SUB, SRC_RAM, SL_X, SRC_RAM, SL_T1, SL_DT, END_NONE);
      6'd5:  u = ar(FP_MUL, SRC_RAM, SL_DT, SRC_RAM, SL_T2, SL_A, END_NONE);
      6'd6:  u = ar(FP_MUL, SRC_RAM, SL_DT, SRC_RAM, SL_DT, SL_SQ, END_NONE);
      6'd7:  u = ar(FP_MUL, SRC_RAM, SL_SQ, SRC_RAM, SL_T3, SL_B, END_NONE);
      6'd8:  u = ar(FP_ADD, SRC_RAM, SL_A, SRC_RAM, SL_B, SL_TN, END_TEMP);
      6'd9:  u = cv(INT_P1, -8'sd20, SL_P1);
      6'd10: u = cv(INT_P2, -8'sd29, SL_P2);
      6'd11: u = cv(INT_P3, -8'sd32, SL_P3);
      6'd12: u = cv(INT_P4, -8'sd37, SL_P4);
      6'd13: u = cv(INT_P5, 8'sd3, SL_P5);
      6'd14: u = cv(INT_P6, -8'sd6, SL_P6);
      6'd15: u = cv(INT_P7, -8'sd8, SL_P7);
      6'd16: u = cv(INT_P8, -8'sd15, SL_P8);
      6'd17: u = cv(INT_P9, -8'sd48, SL_P9);
      6'd18: u = cv(INT_P10, -8'sd48, SL_P10);
      6'd19: u = cv(INT_P11, -8'sd65, SL_P11);
      6'd20: u = cv(INT_RAWP, 8'sd0, SL_UP);
      6'd21: u = ar(FP_MUL, SRC_TEMP, SL_T1, SRC_TEMP, SL_T1, SL_TT, END_NONE);
      6'd22: u = ar(FP_MUL, SRC_RAM, SL_TT, SRC_TEMP, SL_T1, SL_TTT, END_NONE);
      6'd23: u = ar(FP_MUL, SRC_RAM, SL_UP, SRC_RAM, SL_UP, SL_UP2, END_NONE);
      6'd24: u = ar(FP_MUL, SRC_RAM, SL_UP2, SRC_RAM, SL_UP, SL_UP3, END_NONE);
      6'd25: u = ar(FP_MUL, SRC_RAM, SL_P6, SRC_TEMP, SL_T1, SL_M, END_NONE);
      6'd26: u = ar(FP_ADD, SRC_RAM, SL_P5, SRC_RAM, SL_M, SL_O1, END_NONE);
      6'd27: u = ar(FP_MUL, SRC_RAM, SL_P7, SRC_RAM, SL_TT, SL_M, END_NONE);
      6'd28: u = ar(FP_ADD, SRC_RAM, SL_O1, SRC_RAM, SL_M, SL_O1, END_NONE);
      6'd29: u = ar(FP_MUL, SRC_RAM, SL_P8, SRC_RAM, SL_TTT, SL_M, END_NONE);
      6'd30: u = ar(FP_ADD, SRC_RAM, SL_O1, SRC_RAM, SL_M, SL_O1, END_NONE);
      6'd31: u = ar(FP_MUL, SRC_RAM, SL_P2, SRC_TEMP, SL_T1, SL_M, END_NONE);
      6'd32: u = ar(FP_ADD, SRC_RAM, SL_P1, SRC_RAM, SL_M, SL_S, END_NONE);
      6'd33: u = ar(FP_MUL, SRC_RAM, SL_P3, SRC_RAM, SL_TT, SL_M, END_NONE);
      6'd34: u = ar(FP_ADD, SRC_RAM, SL_S, SRC_RAM, SL_M, SL_S, END_NONE);
      6'd35: u = ar(FP_MUL, SRC_RAM, SL_P4, SRC_RAM, SL_TTT, SL_M, END_NONE);
      6'd36: u = ar(FP_ADD, SRC_RAM, SL_S, SRC_RAM, SL_M, SL_S, END_NONE);
      6'd37: u = ar(FP_MUL, SRC_RAM, SL_UP, SRC_RAM, SL_S, SL_O2, END_NONE);
      6'd38: u = ar(FP_MUL, SRC_RAM, SL_P10, SRC_TEMP, SL_T1, SL_M, END_NONE);
      6'd39: u = ar(FP_ADD, SRC_RAM, SL_P9, SRC_RAM, SL_M, SL_S, END_NONE);
      6'd40: u = ar(FP_MUL, SRC_RAM, SL_UP2, SRC_RAM, SL_S, SL_O3, END_NONE);
      6'd41: u = ar(FP_MUL, SRC_RAM, SL_UP3, SRC_RAM, SL_P11, SL_O4, END_NONE);
      6'd42: u = ar(FP_ADD, SRC_RAM, SL_O1, SRC_RAM, SL_O2, SL_S, END_NONE);
      6'd43: u = ar(FP_ADD, SRC_RAM, SL_S, SRC_RAM, SL_O3, SL_S, END_NONE);
      6'd44: u = ar(FP_ADD, SRC_RAM, SL_S, SRC_RAM, SL_O4, SL_RES, END_PRESS);
      default: u = ar(FP_ADD, SRC_RAM, SL_S, SRC_RAM, SL_O4, SL_RES, END_PRESS);
    endcase
    return u;
  endfunction

endpackage

FILE: src/btpc_ram.sv
// Generic RAM with one write port and two registered read ports.
module btpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/btpc_fpu.sv
// Three-stage binary32 unit: add, subtract, multiply and scaled integer conversion.
module btpc_fpu
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fp_cmd_t     cmd,
  output logic        done,
  output logic [31:0] result
);

  localparam int MW = 50;

  // Operand fields.
  logic        sa, sb, sbe;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic [8:0]  na, nb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  // Adder alignment.
  logic        a_big;
  logic [23:0] m_l, m_s;
  logic [8:0]  e_l, e_s;
  logic        s_l, s_s;
  logic [8:0]  d;
  logic [4:0]  dc;
  logic [58:0] sh_w;
  logic [26:0] al;
  logic [27:0] sum;
  logic [24:0] imag;

  // Stage 1 results.
  logic                 c_sign, c_zsign, c_nan, c_inf;
  logic [MW-1:0]        c_m;
  logic signed [11:0]   c_x;

  logic                 s1_sign, s1_zsign, s1_nan, s1_inf;
  logic [MW-1:0]        s1_m;
  logic signed [11:0]   s1_x;
  logic [5:0]           lz_p;

  logic                 s2_sign, s2_zsign, s2_nan, s2_inf;
  logic [MW-1:0]        s2_m;
  logic signed [11:0]   s2_x;
  logic [5:0]           s2_p;

  logic v1, v2, v3;

  // Unpack and form an exact value M * 2^X for each operation.
  always_comb begin
    sa     = cmd.a[31];
    ea     = cmd.a[30:23];
    fa     = cmd.a[22:0];
    sb     = cmd.b[31];
    eb     = cmd.b[30:23];
    fb     = cmd.b[22:0];
    sbe    = sb ^ (cmd.op == FP_SUB);
    ma     = {ea != 8'd0, fa};
    mb     = {eb != 8'd0, fb};
    na     = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
    nb     = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
    nan_a  = (ea == 8'hFF) && (fa != 23'd0);
    nan_b  = (eb == 8'hFF) && (fb != 23'd0);
    inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    zero_a = (ea == 8'd0) && (fa == 23'd0);
    zero_b = (eb == 8'd0) && (fb == 23'd0);

    a_big = cmd.a[30:0] >= cmd.b[30:0];
    m_l   = a_big ? ma : mb;
    m_s   = a_big ? mb : ma;
    e_l   = a_big ? na : nb;
    e_s   = a_big ? nb : na;
    s_l   = a_big ? sa : sbe;
    s_s   = a_big ? sbe : sa;
    d     = e_l - e_s;
    dc    = (d > 9'd31) ? 5'd31 : d[4:0];
    sh_w  = {m_s, 3'b000, 32'd0} >> dc;
    al    = {sh_w[58:33], sh_w[32] | (|sh_w[31:0])};
    sum   = (s_l == s_s) ? ({1'b0, m_l, 3'b000} + {1'b0, al})
                         : ({1'b0, m_l, 3'b000} - {1'b0, al});
    imag  = cmd.ival[INT_W-1] ? 25'(-cmd.ival) : 25'(cmd.ival);

    case (cmd.op)
      FP_MUL: begin
        c_nan   = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
        c_inf   = inf_a || inf_b;
        c_sign  = sa ^ sb;
        c_zsign = sa ^ sb;
        c_m     = MW'(ma * mb);
        c_x     = $signed({3'b000, na}) + $signed({3'b000, nb}) - 12'sd300;
      end
      FP_CVT: begin
        c_nan   = 1'b0;
        c_inf   = 1'b0;
        c_sign  = cmd.ival[INT_W-1];
        c_zsign = 1'b0;
        c_m     = MW'(imag);
        c_x     = 12'(cmd.adj);
      end
      default: begin
        c_nan   = nan_a || nan_b || (inf_a && inf_b && (sa != sbe));
        c_inf   = inf_a || inf_b;
        c_sign  = inf_a ? sa : (inf_b ? sbe : s_l);
        c_zsign = sa & sbe;
        c_m     = MW'(sum);
        c_x     = $signed({3'b000, e_l}) - 12'sd153;
      end
    endcase
  end

  // Position of the leading one.
  always_comb begin
    lz_p = '0;
    for (int i = 0; i < MW; i++) begin
      if (s1_m[i]) begin
        lz_p = 6'(i);
      end
    end
  end

  // Stage 3: shift to 24 bits, round to nearest even, pack.
  logic signed [13:0] be, sub_x, rsh, ben;
  logic [4:0]         lsh;
  logic [5:0]         rc;
  logic [MW-1:0]      shl;
  logic [MW+63:0]     wide;
  logic [24:0]        kept, rnd;
  logic               g, st;
  logic [31:0]        total;
  logic [31:0]        packed_r;

  always_comb begin
    be    = $signed({8'd0, s2_p}) + 14'(s2_x) + 14'sd127;
    sub_x = (be < 14'sd1) ? (14'sd1 - be) : 14'sd0;
    ben   = (be < 14'sd1) ? 14'sd1 : be;
    rsh   = $signed({8'd0, s2_p}) - 14'sd23 + sub_x;
    lsh   = 5'(-rsh);
    rc    = (rsh > 14'sd63) ? 6'd63 : rsh[5:0];
    shl   = s2_m << lsh;
    wide  = {s2_m, 64'd0} >> rc;
    if (rsh <= 14'sd0) begin
      kept = shl[24:0];
      g    = 1'b0;
      st   = 1'b0;
    end else begin
      kept = wide[88:64];
      g    = wide[63];
      st   = |wide[62:0];
    end
    rnd   = kept + {24'd0, g & (st | kept[0])};
    total = {ben[8:0] - 9'd1, 23'd0} + {7'd0, rnd};
    if (s2_nan) begin
      packed_r = 32'h7FC0_0000;
    end else if (s2_inf || (total[31:23] >= 9'd255)) begin
      packed_r = {s2_sign, 8'hFF, 23'd0};
    end else if (s2_m == '0) begin
      packed_r = {s2_zsign, 31'd0};
    end else begin
      packed_r = {s2_sign, total[30:0]};
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    s1_sign  <= c_sign;
    s1_zsign <= c_zsign;
    s1_nan   <= c_nan;
    s1_inf   <= c_inf;
    s1_m     <= c_m;
    s1_x     <= c_x;
    s2_sign  <= s1_sign;
    s2_zsign <= s1_zsign;
    s2_nan   <= s1_nan;
    s2_inf   <= s1_inf;
    s2_m     <= s1_m;
    s2_x     <= s1_x;
    s2_p     <= lz_p;
    result   <= packed_r;
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign done = v3;

endmodule

FILE: src/barometric_temp_pressure_compensation_top.sv
// Top level: sequencer, calibration registers and output register of the compensation block.
//
// Input channel in_valid/in_ready/in_data carries one beat with an optional raw
// temperature and an optional raw pressure. Output channel out_valid/out_ready/out_data
// returns one beat per input beat with binary32 results; absent results read zero.
// Calibration bytes are written through cfg_we/cfg_addr/cfg_data; the user must write them
// only while the block is idle, since the block itself does not enforce it.
// One shared three-stage floating-point unit executes a microprogram; each step passes
// through operand memory read, issue, and three unit stages with write-back.
// When neither sample is present, the beat goes straight to the completion state.
// in_ready is high only while the sequencer is idle, so one beat is in work at a time.
// A finished beat waits in the output register; if the receiver stalls, the next beat
// may still be accepted and computed, and waits until the register is free.
// Reset clears the calibration registers, the kept temperature (to positive zero)
// and the control state; the scratch memory needs no clearing.
module barometric_temp_pressure_compensation_top
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t       state;
  pc_t          pc;
  in_t          item;
  out_t         res;
  logic [31:0]  last_temp;
  logic [63:0]  cal_lo, cal_mid;
  logic [39:0]  cal_hi;
  logic [167:0] cal;
  uop_t         uop;
  fp_cmd_t      cmd;
  logic [31:0]  rdata_a, rdata_b, fp_result;
  logic         fp_done, ram_we;
  logic signed [INT_W-1:0] ival;

  assign cal = {cal_hi, cal_mid, cal_lo};
  assign uop = btpc_prog(pc);

  // Integer operand selection from the calibration fields and raw samples.
  always_comb begin
    case (uop.isel)
      INT_T1:   ival = $signed({9'd0, cal[15:0]});
      INT_T2:   ival = $signed({9'd0, cal[31:16]});
      INT_T3:   ival = $signed({{17{cal[39]}}, cal[39:32]});
      INT_RAWT: ival = $signed({1'b0, item.raw_temperature});
      INT_P1:   ival = $signed({{9{cal[55]}}, cal[55:40]}) - 25'sd16384;
      INT_P2:   ival = $signed({{9{cal[71]}}, cal[71:56]}) - 25'sd16384;
      INT_P3:   ival = $signed({{17{cal[79]}}, cal[79:72]});
      INT_P4:   ival = $signed({{17{cal[87]}}, cal[87:80]});
      INT_P5:   ival = $signed({9'd0, cal[103:88]});
      INT_P6:   ival = $signed({9'd0, cal[119:104]});
      INT_P7:   ival = $signed({{17{cal[127]}}, cal[127:120]});
      INT_P8:   ival = $signed({{17{cal[135]}}, cal[135:128]});
      INT_P9:   ival = $signed({{9{cal[151]}}, cal[151:136]});
      INT_P10:  ival = $signed({{17{cal[159]}}, cal[159:152]});
      INT_P11:  ival = $signed({{17{cal[167]}}, cal[167:160]});
      INT_RAWP: ival = $signed({1'b0, item.raw_pressure});
      default:  ival = '0;
    endcase
  end

  // Command to the shared unit.
  always_comb begin
    cmd.op   = uop.op;
    cmd.a    = (uop.a_src == SRC_TEMP) ? last_temp : rdata_a;
    cmd.b    = (uop.b_src == SRC_TEMP) ? last_temp : rdata_b;
    cmd.ival = ival;
    cmd.adj  = uop.adj;
  end

  assign ram_we   = (state == ST_WAIT) && fp_done;
  assign in_ready = (state == ST_IDLE);

  btpc_ram #(
    .WIDTH (32),
    .DEPTH (SCRATCH_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (uop.dst),
    .wdata   (fp_result),
    .raddr_a (uop.a_addr),
    .raddr_b (uop.b_addr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  btpc_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_EXEC),
    .cmd    (cmd),
    .done   (fp_done),
    .result (fp_result)
  );

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_lo  <= '0;
      cal_mid <= '0;
      cal_hi  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LO:  cal_lo  <= cfg_data;
        CFG_MID: cal_mid <= cfg_data;
        CFG_HI:  cal_hi  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Payload held for the beat in work.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
      res  <= '0;
    end else if (ram_we && (uop.endk == END_TEMP)) begin
      res.temp_ok          <= 1'b1;
      res.temperature_bits <= fp_result;
    end else if (ram_we && (uop.endk == END_PRESS)) begin
      res.press_ok      <= 1'b1;
      res.pressure_bits <= fp_result;
    end
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      last_temp <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills from the completion state and empties on a taken beat.
      if ((state == ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.temp_present) begin
              pc    <= '0;
              state <= ST_READ;
            end else if (in_data.press_present) begin
              pc    <= PC_PRESS;
              state <= ST_READ;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_READ: state <= ST_EXEC;
        ST_EXEC: state <= ST_WAIT;
        ST_WAIT: begin
          if (fp_done) begin
            case (uop.endk)
              END_TEMP: begin
                last_temp <= fp_result;
                if (item.press_present) begin
                  pc    <= PC_PRESS;
                  state <= ST_READ;
                end else begin
                  state <= ST_DONE;
                end
              end
              END_PRESS: state <= ST_DONE;
              default: begin
                pc    <= pc + 6'd1;
                state <= ST_READ;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The unit only completes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    fp_done |-> (state == ST_WAIT))
    else $error("floating-point result arrived outside the wait state");

  // An accepted beat closes the input right after its acceptance.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after acceptance");

  // The program counter stays inside the microprogram.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (pc <= PC_LAST))
    else $error("program counter ran past the last step");

  // A result is presented only from the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("output beat raised without a completed item");

endmodule
